// ----- rtl/tsps_pkg.sv -----
// shared types, constants and register codes of the timed speed program sequencer
package tsps_pkg;

	localparam int SLOT_COUNT = 6;
	localparam int SLOT_IDX_W = $clog2(SLOT_COUNT + 1);
	localparam int FREQ_W = 16;
	localparam int PERIOD_W = 16;
	localparam int WORD_W = FREQ_W + PERIOD_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [FREQ_W-1:0] LOW_FREQ_RST = 16'd2500;
	localparam logic [FREQ_W-1:0] HIGH_FREQ_RST = 16'd50000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_FREQ  = 3'd0,
		REG_HIGH_FREQ = 3'd1,
		REG_SLOT_0    = 3'd2,
		REG_SLOT_1    = 3'd3,
		REG_SLOT_2    = 3'd4,
		REG_SLOT_3    = 3'd5,
		REG_SLOT_4    = 3'd6,
		REG_SLOT_5    = 3'd7
	} cfg_reg_e;

	typedef enum logic {
		KIND_TICK   = 1'b0,
		KIND_SAMPLE = 1'b1
	} kind_e;

	typedef enum logic {
		ACT_SET_FREQ = 1'b0,
		ACT_RELAY_ON = 1'b1
	} action_e;

	typedef struct packed {
		logic kind;
		logic door_open;
		logic item_ready;
		logic voltage_ok;
	} item_t;

	typedef struct packed {
		logic              action;
		logic [FREQ_W-1:0] frequency;
		logic              job_done;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [FREQ_W-1:0]                 low_frequency;
		logic [FREQ_W-1:0]                 high_frequency;
		logic [SLOT_COUNT-1:0][WORD_W-1:0] slot_words;
	} cfg_t;

	function automatic logic [WORD_W-1:0] slot_reset(input int i);
		logic [WORD_W-1:0] w;
		case (i)
			0: w = 32'd655360100;
			1: w = 32'd163840200;
			2: w = 32'd3276800300;
			3: w = 32'd327680400;
			4: w = 32'd360448500;
			5: w = 32'd393216600;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/tsps_cfg.sv -----
// configuration register file: low and high frequency and the slot words
module tsps_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [tsps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsps_pkg::CFG_DATA_W-1:0]    cfg_data,
	output tsps_pkg::cfg_t                     cfg
);
	import tsps_pkg::*;

	cfg_t                 cfg_q;
	logic [CFG_IDX_W-1:0] slot_sel;

	assign slot_sel = cfg_index - CFG_IDX_W'(REG_SLOT_0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_frequency <= LOW_FREQ_RST;
			cfg_q.high_frequency <= HIGH_FREQ_RST;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				cfg_q.slot_words[i] <= slot_reset(i);
			end
		end else if (cfg_valid) begin
			if (cfg_index == REG_LOW_FREQ) begin
				cfg_q.low_frequency <= cfg_data[FREQ_W-1:0];
			end
			if (cfg_index == REG_HIGH_FREQ) begin
				cfg_q.high_frequency <= cfg_data[FREQ_W-1:0];
			end
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (cfg_index >= REG_SLOT_0 && slot_sel == CFG_IDX_W'(i)) begin
					cfg_q.slot_words[i] <= cfg_data[WORD_W-1:0];
				end
			end
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/tsps_core.sv -----
// program state and the per-item decision logic, up to two results per item
module tsps_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  tsps_pkg::item_t   item,
	input  tsps_pkg::cfg_t    cfg,
	output tsps_pkg::result_t res0,
	output tsps_pkg::result_t res1,
	output logic [1:0]        res_cnt
);
	import tsps_pkg::*;

	logic [PERIOD_W-1:0]   tick_q, tick_d;
	logic [SLOT_IDX_W-1:0] slot_q, slot_d;
	logic                  running_q, running_d;
	logic                  ready_seen_q, ready_seen_d;
	logic                  door_seen_q, door_seen_d;

	logic [SLOT_IDX_W-1:0] nxt;
	logic [WORD_W-1:0]     cur_word, nxt_word;
	logic [PERIOD_W-1:0]   tick_inc;
	result_t               ra, rb;
	logic                  have_a, have_b;

	function automatic logic [WORD_W-1:0] slot_word(
		input logic [SLOT_COUNT-1:0][WORD_W-1:0] words,
		input logic [SLOT_IDX_W-1:0]             idx
	);
		logic [WORD_W-1:0] w;
		w = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (idx == SLOT_IDX_W'(i)) begin
				w = words[i];
			end
		end
		return w;
	endfunction

	function automatic result_t set_freq(input logic [FREQ_W-1:0] f, input logic done);
		result_t r;
		r.action = ACT_SET_FREQ;
		r.frequency = f;
		r.job_done = done;
		r.last = 1'b0;
		return r;
	endfunction

	assign nxt = slot_q + 1'b1;
	assign cur_word = slot_word(cfg.slot_words, slot_q);
	assign nxt_word = slot_word(cfg.slot_words, nxt);
	assign tick_inc = tick_q + 1'b1;

	always_comb begin
		tick_d = tick_q;
		slot_d = slot_q;
		running_d = running_q;
		ready_seen_d = ready_seen_q;
		door_seen_d = door_seen_q;
		ra = set_freq('0, 1'b0);
		rb = set_freq('0, 1'b0);
		have_a = 1'b0;
		have_b = 1'b0;
		if (item.kind == KIND_TICK) begin
			if (running_q) begin
				if (tick_inc < cur_word[PERIOD_W-1:0]) begin
					tick_d = tick_inc;
				end else begin
					tick_d = '0;
					if (nxt >= SLOT_IDX_W'(SLOT_COUNT) || nxt_word[PERIOD_W-1:0] == '0) begin
						running_d = 1'b0;
						slot_d = '0;
						ra = set_freq(cfg.low_frequency, 1'b1);
						have_a = 1'b1;
					end else begin
						slot_d = nxt;
						if (!item.door_open) begin
							ra = set_freq(nxt_word[WORD_W-1:PERIOD_W], 1'b0);
							have_a = 1'b1;
						end
					end
				end
			end
		end else if (item.door_open) begin
			if (!door_seen_q) begin
				door_seen_d = 1'b1;
				ra = set_freq(cfg.high_frequency, 1'b0);
				have_a = 1'b1;
			end
		end else begin
			if (door_seen_q) begin
				door_seen_d = 1'b0;
				ra = set_freq(running_q ? cur_word[WORD_W-1:PERIOD_W] : cfg.low_frequency,
					1'b0);
				have_a = 1'b1;
			end
			if (item.item_ready) begin
				if (!ready_seen_q) begin
					ready_seen_d = 1'b1;
					running_d = 1'b1;
					rb = set_freq(cur_word[WORD_W-1:PERIOD_W], 1'b0);
					have_b = 1'b1;
				end
			end else begin
				ready_seen_d = 1'b0;
				if (!running_q && item.voltage_ok) begin
					rb.action = ACT_RELAY_ON;
					have_b = 1'b1;
				end
			end
		end
	end

	always_comb begin
		res_cnt = {1'b0, have_a} + {1'b0, have_b};
		res0 = have_a ? ra : rb;
		res1 = rb;
		res0.last = (res_cnt == 2'd1);
		res1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			slot_q <= '0;
			running_q <= 1'b0;
			ready_seen_q <= 1'b0;
			door_seen_q <= 1'b0;
		end else if (fire) begin
			tick_q <= tick_d;
			slot_q <= slot_d;
			running_q <= running_d;
			ready_seen_q <= ready_seen_d;
			door_seen_q <= door_seen_d;
		end
	end

	// slot pointer never leaves the program
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < SLOT_IDX_W'(SLOT_COUNT))
		else $error("slot index past the program");

	// a stopped program sits at its start
	a_stopped_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (slot_q == '0 && tick_q == '0))
		else $error("stopped program not reset");

	// a completion drops the run flag
	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_cnt != 2'd0 && res0.job_done) |=> !running_q)
		else $error("completion left program running");

endmodule

// ----- rtl/tsps_outq.sv -----
// two-entry result queue between the decision logic and the output channel
module tsps_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  tsps_pkg::result_t res0,
	input  tsps_pkg::result_t res1,
	input  logic [1:0]        res_cnt,
	output logic              can_take,
	output logic              out_valid,
	input  logic              out_ready,
	output tsps_pkg::result_t head
);
	import tsps_pkg::*;

	result_t    e0_q, e1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop = out_valid && out_ready;
	assign can_take = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
	assign head = e0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (fire) begin
			cnt_q <= res_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			e0_q <= res0;
			e1_q <= res1;
		end else if (pop) begin
			e0_q <= e1_q;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue overfilled");

	// new results only land in a queue that is empty or drains this cycle
	a_fire_empty: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)))
		else $error("results written over pending transfer");

	// the second entry of a pair always closes the item
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> (e1_q.last && !e0_q.last))
		else $error("last flag misplaced in result pair");

endmodule

// ----- rtl/timed_speed_program_sequencer_top.sv -----
// top level of the timed speed program sequencer: input register, core, result queue
// Runs a frequency inverter through up to six timed speed slots. Each input
// transfer is a 100 ms tick or a sample of the door, item-ready and voltage
// levels, and yields zero, one or two command results, the last one flagged by
// last. An accepted item is held in the input register, decided in one pass once
// the result queue can take it, and its results are registered in that queue.
// With a ready sink the queue delivers one result per cycle, an item with at most
// one result is taken every cycle and one with two holds off the next item while
// both are queued. Configuration writes are taken at any time (cfg_ready is
// always high) but must only be issued while no item is in flight.
module timed_speed_program_sequencer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic                            door_open,
	input  logic                            item_ready,
	input  logic                            voltage_ok,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            action,
	output logic [tsps_pkg::FREQ_W-1:0]     frequency,
	output logic                            job_done,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tsps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsps_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tsps_pkg::*;

	item_t      item_s1;
	logic       valid_s1;
	logic       fire;
	logic       can_take;
	cfg_t       cfg;
	result_t    res0, res1, head;
	logic [1:0] res_cnt;

	assign cfg_ready = 1'b1;
	assign fire = valid_s1 && can_take;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{kind: kind, door_open: door_open, item_ready: item_ready,
				voltage_ok: voltage_ok};
		end
	end

	tsps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tsps_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.cfg     (cfg),
		.res0    (res0),
		.res1    (res1),
		.res_cnt (res_cnt)
	);

	tsps_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res0      (res0),
		.res1      (res1),
		.res_cnt   (res_cnt),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign action = head.action;
	assign frequency = head.frequency;
	assign job_done = head.job_done;
	assign last = head.last;

endmodule
